// ===== sv/heater_fault_supervisor_top_macros.svh =====
// Assertion macros for the heater fault supervisor top level.
// Depends on clk_i and rst_ni being visible at the point of use.
`ifndef HEATER_FAULT_SUPERVISOR_TOP_MACROS_SVH
`define HEATER_FAULT_SUPERVISOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hfs_pkg.sv =====
// Shared types and constants of the heater fault supervisor.
// No dependencies; every other file of the block but the macro header imports this package.
package hfs_pkg;

  localparam int TempW    = 10;
  localparam int RiseW    = 9;
  localparam int TimeoutW = 16;
  localparam int ErrW     = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgOverheatLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRiseThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTroubleTimeout = 2'd2;

  // Configuration reset values.
  localparam logic signed [TempW-1:0] OverheatReset = 10'sd180;
  localparam logic [RiseW-1:0]        RiseReset     = 9'd10;
  localparam logic [TimeoutW-1:0]     TimeoutReset  = 16'd1200;

  localparam logic [TimeoutW-1:0] TicksMax = '1;

  typedef enum logic {
    OpObserve  = 1'b0,
    OpEvaluate = 1'b1
  } hfs_op_e;

  typedef enum logic [ErrW-1:0] {
    ErrNone     = 3'd0,
    ErrSensor   = 3'd1,
    ErrNoWater  = 3'd2,
    ErrOverheat = 3'd3,
    ErrHeater   = 3'd4,
    ErrFlash    = 3'd5
  } hfs_err_e;

  typedef struct packed {
    hfs_op_e                  op;
    logic signed [TempW-1:0]  temperature;
    logic                     sensor_ok;
    logic                     heater_on;
    logic                     flash_ok;
  } hfs_cmd_t;

  typedef struct packed {
    logic             no_water;
    logic [ErrW-1:0]  error_code;
    logic             pop;
    logic             out_stall;
  } hfs_status_t;

endpackage

// ===== sv/hfs_if.sv =====
// Stream interfaces for the input ticks and the result items.
// Depends on hfs_pkg for the field widths.
interface hfs_in_if;
  import hfs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [TempW-1:0] temperature;
  logic                    sensor_ok;
  logic                    heater_on;
  logic                    flash_ok;

  modport source (output valid, kind, temperature, sensor_ok, heater_on, flash_ok,
                  input ready);
  modport sink (input valid, kind, temperature, sensor_ok, heater_on, flash_ok,
                output ready);
endinterface

interface hfs_out_if;
  import hfs_pkg::*;
  logic            valid;
  logic            ready;
  logic [ErrW-1:0] error_code;
  logic            no_water;

  modport source (output valid, error_code, no_water, input ready);
  modport sink (input valid, error_code, no_water, output ready);
endinterface

// ===== sv/hfs_front.sv =====
// Front end: accepts input ticks, decodes the tick kind and holds one command.
// Depends on hfs_pkg and hfs_in_if.
module hfs_front
  import hfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  hfs_in_if.sink    in_i,
  output logic      cmd_vld_o,
  output hfs_cmd_t  cmd_o,
  input  logic      cmd_rdy_i
);

  logic     vld_q, vld_d;
  hfs_cmd_t cmd_q, cmd_d;
  logic     take;

  assign in_i.ready = !vld_q || cmd_rdy_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    cmd_d = cmd_q;
    vld_d = vld_q;
    if (take) begin
      cmd_d.op          = in_i.kind ? OpEvaluate : OpObserve;
      cmd_d.temperature = in_i.temperature;
      cmd_d.sensor_ok   = in_i.sensor_ok;
      cmd_d.heater_on   = in_i.heater_on;
      cmd_d.flash_ok    = in_i.flash_ok;
      vld_d             = 1'b1;
    end else if (cmd_rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_vld_o = vld_q;
  assign cmd_o     = cmd_q;

endmodule

// ===== sv/hfs_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on hfs_pkg.
module hfs_queue
  import hfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_vld_i,
  input  hfs_cmd_t  push_cmd_i,
  output logic      push_rdy_o,
  output logic      pop_vld_o,
  output hfs_cmd_t  pop_cmd_o,
  input  logic      pop_rdy_i
);

  hfs_cmd_t         mem_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_rdy_o = cnt_q != QCntW'(QueueDepth);
  assign pop_vld_o  = cnt_q != '0;
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_vld_o && pop_rdy_i;
  assign pop_cmd_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== sv/hfs_back.sv =====
// Back end: configuration registers, sample window, error logic, result register.
// Depends on hfs_pkg and hfs_out_if.
module hfs_back
  import hfs_pkg::*;
#(
  parameter int WINDOW = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                cmd_vld_i,
  input  hfs_cmd_t            cmd_i,
  output logic                cmd_rdy_o,
  hfs_out_if.source           out_o,
  output hfs_status_t         status_o
);

  localparam int FillW = $clog2(WINDOW + 1);
  localparam int IdxW  = $clog2(WINDOW);

  logic signed [TempW-1:0] ovh_q;
  logic [RiseW-1:0]        rise_q;
  logic [TimeoutW-1:0]     tmo_q;

  logic signed [TempW-1:0] win_q [WINDOW];
  logic signed [TempW-1:0] win_d [WINDOW];
  logic [FillW-1:0]        fill_q, fill_d;
  logic                    full_q, full_d;
  logic                    nw_q, nw_d;
  hfs_err_e                err_q, err_d;
  logic signed [TempW-1:0] prev_q, prev_d;
  logic [TimeoutW-1:0]     ticks_q, ticks_d;
  logic                    out_vld_q, out_vld_d;

  logic                    pop, tracking, rise_hit, elapsed;
  logic signed [TempW-1:0] temp;
  logic signed [TempW:0]   base;
  logic [TimeoutW-1:0]     ticks_inc;

  assign cmd_rdy_o = !out_vld_q || out_o.ready;
  assign pop       = cmd_vld_i && cmd_rdy_o;
  assign temp      = cmd_i.temperature;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovh_q  <= OverheatReset;
      rise_q <= RiseReset;
      tmo_q  <= TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOverheatLimit:  ovh_q  <= cfg_wdata_i[TempW-1:0];
        CfgRiseThreshold:  rise_q <= cfg_wdata_i[RiseW-1:0];
        CfgTroubleTimeout: tmo_q  <= cfg_wdata_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // Observe path: window update, then the rise compare in every cell.
  always_comb begin
    win_d    = win_q;
    fill_d   = fill_q;
    full_d   = full_q;
    tracking = 1'b0;
    if (pop && cmd_i.op == OpObserve) begin
      if (!cmd_i.sensor_ok || nw_q) begin
        fill_d = '0;
        full_d = 1'b0;
      end else begin
        tracking = 1'b1;
        if (!full_q) begin
          if (fill_q >= FillW'(WINDOW)) begin
            full_d = 1'b1;
          end else begin
            win_d[fill_q[IdxW-1:0]] = temp;
            fill_d = fill_q + 1'b1;
          end
        end else begin
          for (int i = 0; i < WINDOW - 1; i++) begin
            win_d[i] = win_q[i + 1];
          end
          win_d[WINDOW-1] = temp;
        end
      end
    end
  end

  always_comb begin
    base     = $signed({win_d[0][TempW-1], win_d[0]}) + $signed({2'b00, rise_q});
    rise_hit = 1'b0;
    for (int i = 1; i < WINDOW; i++) begin
      if (FillW'(i) < fill_d && $signed({win_d[i][TempW-1], win_d[i]}) >= base) begin
        rise_hit = 1'b1;
      end
    end
  end

  // Evaluate path and the remaining state.
  assign ticks_inc = (ticks_q != TicksMax) ? ticks_q + 1'b1 : ticks_q;
  assign elapsed   = ticks_inc >= tmo_q;

  always_comb begin
    nw_d      = nw_q;
    err_d     = err_q;
    ticks_d   = ticks_q;
    prev_d    = prev_q;
    out_vld_d = out_vld_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (pop) begin
      out_vld_d = 1'b1;
      if (cmd_i.op == OpObserve) begin
        if (tracking && rise_hit) begin
          nw_d = 1'b1;
        end
      end else begin
        priority if (!cmd_i.sensor_ok) begin
          err_d = ErrSensor;
        end else if (nw_q) begin
          err_d = ErrNoWater;
        end else if (temp >= ovh_q) begin
          err_d = ErrOverheat;
        end else if (elapsed) begin
          err_d = ErrHeater;
        end else if (!cmd_i.flash_ok) begin
          err_d = ErrFlash;
        end else begin
          // No condition holds: the error code is sticky.
          err_d = err_q;
        end
        ticks_d = ticks_inc;
        if ((cmd_i.heater_on && temp > prev_q) ||
            (err_d != ErrHeater && (!cmd_i.sensor_ok || !cmd_i.heater_on))) begin
          ticks_d = '0;
        end
        prev_d = temp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      full_q    <= 1'b0;
      nw_q      <= 1'b0;
      err_q     <= ErrNone;
      prev_q    <= '0;
      ticks_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      full_q    <= full_d;
      nw_q      <= nw_d;
      err_q     <= err_d;
      prev_q    <= prev_d;
      ticks_q   <= ticks_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // The state changes only on a pop, so it doubles as the result register.
  assign out_o.valid      = out_vld_q;
  assign out_o.error_code = err_q;
  assign out_o.no_water   = nw_q;

  assign status_o.no_water   = nw_q;
  assign status_o.error_code = err_q;
  assign status_o.pop        = pop;
  assign status_o.out_stall  = out_vld_q && !out_o.ready;

endmodule

// ===== sv/heater_fault_supervisor_top.sv =====
// Heater fault supervisor top level: front end, command queue and back end.
// Depends on hfs_pkg, hfs_if, hfs_front, hfs_queue, hfs_back and the macro header.
// Each tick passes the front register, the queue and the result register; one result per tick.
// Throughput: one tick per cycle while the result sink keeps ready high.
// Reset (rst_ni, asynchronous, active low) loads the register defaults and empties the queue.
`include "heater_fault_supervisor_top_macros.svh"

module heater_fault_supervisor_top
  import hfs_pkg::*;
#(
  parameter int WINDOW = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  hfs_in_if.sink              in_i,
  hfs_out_if.source           out_o
);

  // The front end registers each tick transfer and decodes its kind into a command.
  // The queue lets the front end keep taking ticks while a result waits at the output.
  // The back end executes one command per cycle whenever the result register is free;
  // an observe tick updates the sample window and compares every cell against the
  // oldest sample in parallel, an evaluate tick updates the sticky error code.

  logic        f_vld, f_rdy;
  hfs_cmd_t    f_cmd;
  logic        q_vld, q_rdy;
  hfs_cmd_t    q_cmd;
  hfs_status_t status;
  logic        err_raised;

  hfs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cmd_vld_o (f_vld),
    .cmd_o     (f_cmd),
    .cmd_rdy_i (f_rdy)
  );

  hfs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_vld_i (f_vld),
    .push_cmd_i (f_cmd),
    .push_rdy_o (f_rdy),
    .pop_vld_o  (q_vld),
    .pop_cmd_o  (q_cmd),
    .pop_rdy_i  (q_rdy)
  );

  hfs_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_vld_i   (q_vld),
    .cmd_i       (q_cmd),
    .cmd_rdy_o   (q_rdy),
    .out_o       (out_o),
    .status_o    (status)
  );

  assign err_raised = status.error_code != ErrNone;

  // Once latched, the no-water flag never clears.
  `HFS_ASSERT_NEXT(a_no_water_sticky, status.no_water, status.no_water, "no-water flag cleared")
  // A raised error code never returns to no error.
  `HFS_ASSERT_NEXT(a_error_sticky, err_raised, err_raised, "error code cleared")
  // The back end must not consume a command while its result is stalled.
  `HFS_ASSERT_NOW(a_no_pop_on_stall, status.out_stall, !status.pop, "command taken during output stall")

endmodule

// ===== test/heater_fault_supervisor_top_test.sv =====
// Self-checking testbench for heater_fault_supervisor_top: random and directed ticks
// are checked against an in-bench model of the no-water window and the error latch.
// Depends on hfs_pkg, hfs_if and the RTL of the block.
`timescale 1ns / 1ps

module heater_fault_supervisor_top_test;
  import hfs_pkg::*;

  localparam int Window = 20;

  // Expected content of one result transfer.
  typedef struct packed {
    hfs_err_e error_code;
    logic     no_water;
  } heater_status_t;

  // Pacing schemes of the result sink.
  typedef enum int {
    RdyOpen,
    RdyCoin,
    RdyPeriodic,
    RdySparse
  } sink_pace_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CfgOverheatLimit;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  hfs_in_if  tick_if ();
  hfs_out_if status_if ();

  heater_fault_supervisor_top #(
    .WINDOW(Window)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (tick_if.sink),
    .out_o      (status_if.source)
  );

  always #1 clk_i = ~clk_i;

  // Register shadows, loaded with the reset defaults of the block.
  logic signed [TempW-1:0] overheat_lim = OverheatReset;
  logic [RiseW-1:0]        rise_thr = RiseReset;
  logic [TimeoutW-1:0]     trouble_lim = TimeoutReset;

  // Model state. The window entries are only ever read after being written.
  logic signed [TempW-1:0] window_temps [Window];
  int                      window_fill = 0;
  bit                      window_full = 1'b0;
  bit                      dry_latched = 1'b0;
  hfs_err_e                active_err = ErrNone;
  logic signed [TempW-1:0] last_eval_temp = '0;
  logic [TimeoutW-1:0]     progress_ticks = '0;

  // Ticks waiting for the driver, and results waiting for the sink.
  hfs_cmd_t       pending_ticks [$];
  heater_status_t status_due [$];

  int        fault_count = 0;
  int        observe_sent = 0;
  int        evaluate_sent = 0;
  int        status_checked = 0;
  int        settings_count = 1;
  bit [7:0]  err_seen = '0;

  // Stimulus shaping: observe samples stay inside a band narrower than the rise
  // threshold so the window fills and shifts without tripping the no-water latch;
  // evaluate temperatures follow a slow walk so the progress counter can age.
  int band_lo = 0;
  int eval_walk = 0;

  // Advances the model by one tick and returns the result it must produce.
  function automatic heater_status_t supervise_tick(hfs_cmd_t cmd);
    heater_status_t          res;
    logic signed [TempW-1:0] temp;
    logic                    elapsed;
    int                      i;
    temp = cmd.temperature;
    if (cmd.op == OpEvaluate) begin
      if (progress_ticks != TicksMax) progress_ticks = progress_ticks + 1'b1;
      elapsed = progress_ticks >= trouble_lim;
      if (!cmd.sensor_ok) active_err = ErrSensor;
      else if (dry_latched) active_err = ErrNoWater;
      else if (temp >= overheat_lim) active_err = ErrOverheat;
      else if (elapsed) active_err = ErrHeater;
      else if (!cmd.flash_ok) active_err = ErrFlash;
      // Progress restarts on a rising reading with the heater on, and whenever
      // supervision does not apply unless heater trouble is already flagged.
      if ((cmd.heater_on && temp > last_eval_temp) ||
          (active_err != ErrHeater && (!cmd.sensor_ok || !cmd.heater_on))) begin
        progress_ticks = '0;
      end
      last_eval_temp = temp;
    end else if (!cmd.sensor_ok || dry_latched) begin
      window_fill = 0;
      window_full = 1'b0;
    end else begin
      if (!window_full) begin
        // Once the window holds Window samples, one tick only marks it full.
        if (window_fill >= Window) begin
          window_full = 1'b1;
        end else begin
          window_temps[window_fill] = temp;
          window_fill++;
        end
      end else begin
        for (i = 0; i < Window - 1; i++) window_temps[i] = window_temps[i + 1];
        window_temps[Window - 1] = temp;
      end
      for (i = 1; i < window_fill; i++) begin
        if (int'(window_temps[i]) >= int'(window_temps[0]) + int'(rise_thr)) dry_latched = 1'b1;
      end
    end
    err_seen[active_err] = 1'b1;
    res.error_code = active_err;
    res.no_water = dry_latched;
    return res;
  endfunction

  function automatic void push_tick(hfs_op_e op, int temp, bit sensor_ok, bit heater_on,
                                    bit flash_ok);
    hfs_cmd_t cmd;
    cmd.op = op;
    cmd.temperature = TempW'(temp);
    cmd.sensor_ok = sensor_ok;
    cmd.heater_on = heater_on;
    cmd.flash_ok = flash_ok;
    pending_ticks.push_back(cmd);
  endfunction

  // Queues n random ticks. With dry set the no-water latch is expected to be set
  // already, so observe samples are unconstrained.
  function automatic void random_ticks(int n, bit dry);
    int k;
    int temp;
    int pick;
    if (!dry) band_lo = int'($urandom_range(0, 1023 - int'(rise_thr))) - 512;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 45) begin
        if (dry) temp = int'($urandom_range(0, 1023));
        else temp = band_lo + int'($urandom_range(0, int'(rise_thr) - 1));
        push_tick(OpObserve, temp,
                  dry ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) != 0),
                  $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // Same reading again: no progress.
        end else if (pick < 85) begin
          eval_walk = eval_walk - int'($urandom_range(1, 4));
        end else if (pick < 92) begin
          eval_walk = eval_walk + int'($urandom_range(1, 4));
        end else begin
          eval_walk = int'($urandom_range(0, 1023)) - 512;
        end
        if (eval_walk < -512) eval_walk = -512;
        if (eval_walk > 511) eval_walk = 511;
        push_tick(OpEvaluate, eval_walk, $urandom_range(0, 19) != 0,
                  $urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0);
      end
    end
  endfunction

  // Returns at a falling edge once every queued tick has been transferred and
  // every expected result has arrived.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || tick_if.valid || status_due.size() != 0);
  endtask

  // Writes all three registers on consecutive edges; the block is idle here.
  task automatic program_limits(int oh, int rise, int tmo);
    logic signed [TempW-1:0] oh_v;
    logic [RiseW-1:0]        rise_v;
    logic [TimeoutW-1:0]     tmo_v;
    oh_v = TempW'(oh);
    rise_v = RiseW'(rise);
    tmo_v = TimeoutW'(tmo);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CfgOverheatLimit;
    cfg_wdata <= {{(CfgDataW - TempW){oh_v[TempW-1]}}, oh_v};
    @(posedge clk_i);
    cfg_idx <= CfgRiseThreshold;
    cfg_wdata <= {{(CfgDataW - RiseW){1'b0}}, rise_v};
    @(posedge clk_i);
    cfg_idx <= CfgTroubleTimeout;
    cfg_wdata <= tmo_v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    overheat_lim = oh_v;
    rise_thr = rise_v;
    trouble_lim = tmo_v;
    settings_count++;
    // Step off the rising edge so new ticks never race with the driver.
    @(negedge clk_i);
  endtask

  function automatic void note_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] FAULT: %s", $realtime, what);
  endfunction

  // Tick driver. A transfer happens at an edge where valid and ready were both
  // high; the model is stepped right there so expectations keep transfer order.
  // The sender works in bursts with random gaps, and occasionally in long
  // stretches without any gap.
  int burst_left = 16;
  int gap_left = 0;

  always @(posedge clk_i) begin : tick_driver
    hfs_cmd_t sent;
    hfs_cmd_t nxt;
    logic     nxt_valid;
    if (rst_ni) begin
      if (tick_if.valid && tick_if.ready) begin
        sent.op = hfs_op_e'(tick_if.kind);
        sent.temperature = tick_if.temperature;
        sent.sensor_ok = tick_if.sensor_ok;
        sent.heater_on = tick_if.heater_on;
        sent.flash_ok = tick_if.flash_ok;
        status_due.push_back(supervise_tick(sent));
        if (sent.op == OpObserve) observe_sent++;
        else evaluate_sent++;
      end
      // A tick offered but not taken stays on the bus unchanged.
      if (!(tick_if.valid && !tick_if.ready)) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ticks.size() != 0) begin
          nxt = pending_ticks.pop_front();
          nxt_valid = 1'b1;
          tick_if.kind <= nxt.op;
          tick_if.temperature <= nxt.temperature;
          tick_if.sensor_ok <= nxt.sensor_ok;
          tick_if.heater_on <= nxt.heater_on;
          tick_if.flash_ok <= nxt.flash_ok;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
          end
        end
        tick_if.valid <= nxt_valid;
      end
    end
  end

  // Result sink. Every transfer is checked against the oldest expectation; the
  // ready line follows a pacing scheme that is picked anew whenever its countdown runs out.
  sink_pace_e pace_mode = RdyOpen;
  int         pace_left = 40;
  int         pace_step = 0;

  always @(posedge clk_i) begin : status_sink
    heater_status_t exp_status;
    logic           nxt_ready;
    if (rst_ni) begin
      if (status_if.valid && status_if.ready) begin
        if (status_due.size() == 0) begin
          note_fault($sformatf("result with nothing due: error_code %0d no_water %0d",
                               status_if.error_code, status_if.no_water));
        end else begin
          exp_status = status_due.pop_front();
          status_checked++;
          if (status_if.error_code !== exp_status.error_code ||
              status_if.no_water !== exp_status.no_water) begin
            note_fault($sformatf("result %0d: expected error_code %0d no_water %0d, got %0d %0d",
                                 status_checked, exp_status.error_code, exp_status.no_water,
                                 status_if.error_code, status_if.no_water));
          end
        end
      end
      if (pace_left == 0) begin
        pace_mode = sink_pace_e'($urandom_range(0, 3));
        pace_left = $urandom_range(30, 200);
      end else begin
        pace_left--;
      end
      pace_step++;
      case (pace_mode)
        RdyOpen:     nxt_ready = 1'b1;
        RdyCoin:     nxt_ready = $urandom_range(0, 1) != 0;
        RdyPeriodic: nxt_ready = (pace_step % 5) != 4;
        default:     nxt_ready = ($urandom_range(0, 3) == 0);
      endcase
      status_if.ready <= nxt_ready;
    end
  end

  // Main sequence: reset, a directed opening at the reset defaults, then phases
  // of random traffic under different register settings. The no-water latch can
  // only be cleared by reset, so the phases that set it come last.
  initial begin : stimulus
    int ph;
    int k;
    int temp;
    tick_if.valid = 1'b0;
    tick_if.kind = OpObserve;
    tick_if.temperature = '0;
    tick_if.sensor_ok = 1'b0;
    tick_if.heater_on = 1'b0;
    tick_if.flash_ok = 1'b0;
    status_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: error priority and stickiness, overheat at and below the limit,
    // the temperature extremes, and window samples right below the threshold.
    push_tick(OpEvaluate, 0, 1, 1, 1);
    push_tick(OpEvaluate, 0, 1, 1, 0);
    push_tick(OpEvaluate, 180, 1, 1, 1);
    push_tick(OpEvaluate, 179, 1, 1, 1);
    push_tick(OpEvaluate, 511, 1, 0, 0);
    push_tick(OpEvaluate, 511, 0, 1, 0);
    push_tick(OpEvaluate, -512, 0, 0, 1);
    push_tick(OpEvaluate, -512, 1, 1, 1);
    push_tick(OpObserve, 511, 0, 0, 0);
    push_tick(OpObserve, 511, 1, 1, 1);
    push_tick(OpObserve, -512, 1, 0, 1);
    push_tick(OpObserve, 0, 0, 1, 0);
    push_tick(OpObserve, -512, 1, 0, 0);
    push_tick(OpObserve, -503, 1, 1, 1);
    push_tick(OpObserve, -503, 0, 1, 1);
    push_tick(OpEvaluate, 100, 1, 1, 1);
    random_ticks(130, 1'b0);
    wait_idle();

    // Settings sweep: the register extremes including a zero timeout, plus
    // random mid-range values. Each phase opens with a window clear.
    for (ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: program_limits(-512, 511, 0);
        2: program_limits(511, 1, 1);
        3: program_limits(int'($urandom_range(0, 1023)) - 512, $urandom_range(1, 511), 65535);
        4: program_limits(0, 10, $urandom_range(2, 12));
        default: program_limits(int'($urandom_range(0, 600)) - 300, $urandom_range(1, 40),
                                $urandom_range(1, 12));
      endcase
      push_tick(OpObserve, 0, 0, 0, 0);
      random_ticks(140, 1'b0);
      wait_idle();
    end

    // Zero rise threshold: a strictly falling run of samples fills, marks and
    // shifts the window without a latch, then a top-scale sample latches it.
    program_limits(180, 0, 5);
    push_tick(OpObserve, 0, 0, 1, 1);
    temp = $urandom_range(150, 400);
    for (k = 0; k < 22; k++) begin
      push_tick(OpObserve, temp, 1, $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      temp = temp - int'($urandom_range(1, 3));
    end
    push_tick(OpObserve, 511, 1, 1, 1);
    random_ticks(130, 1'b1);
    wait_idle();

    program_limits(int'($urandom_range(0, 1023)) - 512, 511, 1);
    random_ticks(140, 1'b1);
    wait_idle();

    // Results pass the front register, the queue and the result register; give stray ones time to show up.
    repeat (8) @(posedge clk_i);
    if (status_due.size() != 0) note_fault($sformatf("%0d results never arrived",
                                                     status_due.size()));
    $display("Covered %0d observe and %0d evaluate ticks over %0d register settings,",
             observe_sent, evaluate_sent, settings_count);
    $display("%0d results checked. Error codes reached (bit per code): %b, no-water latch %s.",
             status_checked, err_seen[5:0], dry_latched ? "set" : "never set");
    if (fault_count == 0) begin
      $display("heater_fault_supervisor_top_test: done, clean");
    end else begin
      $display("heater_fault_supervisor_top_test: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake: far beyond the slowest correct run.
  initial begin : run_limit
    #2_000_000;
    $display("Run limit hit with %0d ticks queued and %0d results due.",
             pending_ticks.size(), status_due.size());
    $display("heater_fault_supervisor_top_test: done, errors");
    $finish;
  end

endmodule
